[src/rid_pkg.sv]
// Shared types and helpers for the raw image difference decoder.
`timescale 1ns / 1ps
package rid_pkg;

  localparam int unsigned WidthReset  = 4096;
  localparam int unsigned HeightReset = 3072;
  localparam int unsigned HeaderBytes = 7;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // One decoded difference on its way to the predictor.
  typedef struct packed {
    logic        parity;
    logic        row_lt2;
    logic        col_lt2;
    logic [15:0] diff;
    logic        eor;
    logic        eoi;
    logic        last;
  } dec_t;

  // Number of significant bits in a 16-bit value.
  function automatic logic [4:0] bit_len16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  // Number of significant bits in a 12-bit value.
  function automatic logic [3:0] bit_len12(input logic [11:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

[src/rid_bit_decoder.sv]
// Byte intake, bit buffer, adaptive difference decode and raster counters.
`timescale 1ns / 1ps
module rid_bit_decoder #(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             data_byte,
  input  logic [14:0]                            width_reg,
  input  logic [13:0]                            height_reg,
  input  logic                                   adv,
  output logic                                   go,
  output rid_pkg::dec_t                          dec,
  output logic [$clog2(MAX_WIDTH):0]             rd_addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

  logic [47:0]        bbuf;
  logic [5:0]         count;
  logic [2:0]         hdr;
  logic [1:0]         dec_left;
  logic               done;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [15:0]        lmag [2];
  logic [17:0]        rbias [2];
  logic [1:0]         srun [2];

  logic [16:0] w_eff, h_eff;
  logic [31:0] top;
  logic        p, neg, can_dec, finish, accept, append, eor, eoi, last;
  logic [1:0]  low;
  logic [4:0]  act, bias, nlow, tmp;
  logic [3:0]  lz;
  logic [5:0]  used, sh;
  logic [15:0] mask, v;
  logic [31:0] fld;
  logic [19:0] mag;
  logic signed [21:0] s, diff;
  logic signed [23:0] t;
  logic [17:0] rb_new;

  always_comb begin
    w_eff = {2'b0, width_reg};
    if (w_eff > MaxW) w_eff = MaxW;
    w_eff[0] = 1'b0;
    if (w_eff < 17'd2) w_eff = 17'd2;
    h_eff = {3'b0, height_reg};
    if (h_eff > MaxH) h_eff = MaxH;
    if (h_eff < 17'd2) h_eff = 17'd2;

    p    = col[0];
    top  = 32'(bbuf >> (count - 6'd32));
    neg  = top[31];
    low  = top[30:29];
    lz   = 4'd12 - rid_pkg::bit_len12(top[28:17]);
    bias = (srun[p] < 2'd3) ? 5'd2 : 5'd0;
    act  = rid_pkg::bit_len16(lmag[p]);
    tmp  = (act > bias) ? act - bias : 5'd0;
    nlow = (tmp < bias + 5'd2) ? bias + 5'd2 : tmp;
    mask = 16'((17'd1 << nlow) - 17'd1);
    sh   = 6'd28 - 6'(lz) - 6'(nlow);
    fld  = top >> sh;
    v    = top[16:1];
    if (lz != 4'd12) begin
      mag  = (20'(lz) << nlow) | {4'b0, fld[15:0] & mask};
      used = 6'(lz) + 6'd4 + 6'(nlow);
    end else begin
      // escape code: high part inline, one separator bit dropped
      mag  = {4'b0, ((v >> 1) & ~mask) | (v & mask)};
      used = 6'd31;
    end
    s      = neg ? ~$signed({2'b0, mag}) : $signed({2'b0, mag});
    diff   = s + {{4{rbias[p][17]}}, rbias[p]};
    t      = ({diff[21], diff, 1'b0}) + {{2{diff[21]}}, diff}
             + {{6{rbias[p][17]}}, rbias[p]};
    rb_new = t[22:5];

    eor  = ({{(17-CW){1'b0}}, col} + 17'd1) >= w_eff;
    eoi  = eor && (({{(17-RW){1'b0}}, row} + 17'd1) >= h_eff);
    last = (dec_left == 2'd1) || eoi || ((count - used) < 6'd32);

    can_dec  = (dec_left != 2'd0) && (count >= 6'd32) && !done;
    go       = can_dec && adv;
    finish   = (dec_left != 2'd0) && (!can_dec || (go && last));
    in_stall = !((dec_left == 2'd0) || finish);
    accept   = in_valid && !in_stall;
    append   = accept && (hdr == 3'd0) && !done && !(go && eoi);

    dec.parity  = p;
    dec.row_lt2 = ({{(17-RW){1'b0}}, row} < 17'd2);
    dec.col_lt2 = ({{(17-CW){1'b0}}, col} < 17'd2);
    dec.diff    = {diff[13:0], low};
    dec.eor     = eor;
    dec.eoi     = eoi;
    dec.last    = last;
    rd_addr     = {row[0], col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bbuf     <= '0;
      count    <= '0;
      hdr      <= 3'(rid_pkg::HeaderBytes);
      dec_left <= '0;
      done     <= 1'b0;
      col      <= '0;
      row      <= '0;
      for (int i = 0; i < 2; i++) begin
        lmag[i]  <= '0;
        rbias[i] <= '0;
        srun[i]  <= '0;
      end
    end else begin
      if (accept && hdr != 3'd0) hdr <= hdr - 3'd1;
      if (append) begin
        bbuf     <= {bbuf[39:0], data_byte};
        count    <= count - (go ? used : 6'd0) + 6'd8;
        dec_left <= 2'd2;
      end else begin
        if (go) count <= count - used;
        if (finish) dec_left <= 2'd0;
        else if (go) dec_left <= dec_left - 2'd1;
      end
      if (go) begin
        if (eor) begin
          col <= '0;
          if (eoi) done <= 1'b1;
          else row <= row + RW'(1);
          for (int i = 0; i < 2; i++) begin
            lmag[i]  <= '0;
            rbias[i] <= '0;
            srun[i]  <= '0;
          end
        end else begin
          col      <= col + CW'(1);
          lmag[p]  <= mag[15:0];
          rbias[p] <= rb_new;
          if (mag > 20'd16) srun[p] <= 2'd0;
          else if (srun[p] != 2'd3) srun[p] <= srun[p] + 2'd1;
        end
      end
    end
  end

endmodule

[src/rid_predictor.sv]
// Line store, same-colour prediction and output register.
`timescale 1ns / 1ps
module rid_predictor #(
  parameter int MAX_WIDTH = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  rid_pkg::dec_t                 dec,
  input  logic [$clog2(MAX_WIDTH):0]    rd_addr,
  output logic                          adv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   pixel_value,
  output logic                          end_of_row,
  output logic                          end_of_image,
  output logic                          last_of_item
);

  localparam int AW = $clog2(MAX_WIDTH) + 1;

  logic [15:0]   mem [2**AW];
  logic [15:0]   up_q;
  logic          s2_valid;
  rid_pkg::dec_t s2;
  logic [AW-1:0] s2_addr;
  logic [15:0]   left_hold [2];
  logic [15:0]   ul_hold [2];

  logic [15:0] left, nw, pix;
  logic signed [17:0] lm, um, alm, aum, pred;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    left = left_hold[s2.parity];
    nw   = ul_hold[s2.parity];
    lm   = $signed({2'b0, left}) - $signed({2'b0, nw});
    um   = $signed({2'b0, up_q}) - $signed({2'b0, nw});
    alm  = lm[17] ? -lm : lm;
    aum  = um[17] ? -um : um;
    if (s2.row_lt2 && s2.col_lt2) pred = '0;
    else if (s2.row_lt2) pred = {2'b0, left};
    else if (s2.col_lt2) pred = {2'b0, up_q};
    else if ((lm[17] != um[17]) && lm != 0 && um != 0) begin
      if (alm > 18'sd32 || aum > 18'sd32) pred = $signed({2'b0, left}) + um;
      else pred = ($signed({2'b0, left}) + $signed({2'b0, up_q})) >>> 1;
    end else begin
      pred = (alm > aum) ? {2'b0, left} : {2'b0, up_q};
    end
    pix = pred[15:0] + s2.diff;
  end

  always_ff @(posedge clk) begin
    if (adv && go) up_q <= mem[rd_addr];
    if (adv && s2_valid) mem[s2_addr] <= pix;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2      <= dec;
      s2_addr <= rd_addr;
      if (s2_valid) begin
        left_hold[s2.parity] <= pix;
        ul_hold[s2.parity]   <= up_q;
        pixel_value          <= pix;
        end_of_row           <= s2.eor;
        end_of_image         <= s2.eoi;
        last_of_item         <= s2.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= go;
      out_valid <= s2_valid;
    end
  end

endmodule

[src/raw_image_difference_decoder_unit.sv]
// Top level of the raw image difference decoder.
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// input     in         in_valid/in_stall    data_byte (one stream byte)
// output    out        out_valid/out_stall  pixel_value, end_of_row, end_of_image,
//                                           last_of_item
// config    in         cfg_we               cfg_index, cfg_data (no read-back)
//
// Each pixel a byte yields takes its own decode step, so a byte that yields
// two pixels holds the input until its last decode.
// The decode loop (bit window, adaptive carry set, counters) sets the pace.
// After decode a pixel is registered at the line store read, then at predict.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// A stalled output freezes the whole pipe; bytes keep flowing only while no
// decode for the current byte is pending.
module raw_image_difference_decoder_unit #(
  parameter int MAX_WIDTH  = 16384,
  parameter int MAX_HEIGHT = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_value,
  output logic        end_of_row,
  output logic        end_of_image,
  output logic        last_of_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  logic [14:0]   width_reg;
  logic [13:0]   height_reg;
  logic          adv, go;
  rid_pkg::dec_t dec;
  logic [$clog2(MAX_WIDTH):0] rd_addr;

  // sizes are sampled per pixel; the user writes them only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 15'(rid_pkg::WidthReset);
      height_reg <= 14'(rid_pkg::HeightReset);
    end else if (cfg_we) begin
      case (rid_pkg::reg_index_t'(cfg_index))
        rid_pkg::REG_WIDTH:  width_reg  <= cfg_data;
        rid_pkg::REG_HEIGHT: height_reg <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // bit buffer and per-parity adaptive decode
  rid_bit_decoder #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .width_reg (width_reg),
    .height_reg(height_reg),
    .adv       (adv),
    .go        (go),
    .dec       (dec),
    .rd_addr   (rd_addr)
  );

  // two-row line store, prediction, output word register
  rid_predictor #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pred (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .dec         (dec),
    .rd_addr     (rd_addr),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value),
    .end_of_row  (end_of_row),
    .end_of_image(end_of_image),
    .last_of_item(last_of_item)
  );

endmodule

[sim/tb_top.sv]
// Testbench for raw_image_difference_decoder_unit: stream bytes in, check decoded pixels.
`timescale 1ns / 1ps
module tb_top;

  // Effective size limits of the block under test.
  localparam int unsigned WMax = 16384;
  localparam int unsigned HMax = 8192;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] pixel_value;
  logic        end_of_row;
  logic        end_of_image;
  logic        last_of_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [14:0] cfg_data;

  raw_image_difference_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_value (pixel_value),
    .end_of_row  (end_of_row),
    .end_of_image(end_of_image),
    .last_of_item(last_of_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // One decoded pixel word as it should leave the block.
  typedef struct {
    logic [15:0] pix;
    logic        eor;
    logic        eoi;
    logic        last;
  } pixel_word_t;

  pixel_word_t pending_pixels[$];
  int          fail_count;

  // Decoder shadow state.
  logic [14:0]  shadow_width;
  logic [13:0]  shadow_height;
  logic [63:0]  bits_held;
  int unsigned  bits_avail;
  int unsigned  header_todo;
  int unsigned  cur_row;
  int unsigned  cur_col;
  bit           image_finished;
  int unsigned  prev_mag[2];
  int           carry_bias[2];
  int unsigned  quiet_run[2];
  logic [15:0]  row_pair[0:2*WMax-1];
  logic [15:0]  upleft_pix[2];

  // Receiver stall control.
  int          hold_cycles;
  int          stall_mode;
  logic [15:0] stall_pattern;
  int          stall_phase;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("** raw_image_difference_decoder_unit: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // ---------------- predictor ----------------

  function automatic int unsigned sig_bits(input int unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic int unsigned peek_stream(input int unsigned n);
    if (n == 0 || n > bits_avail) return 0;
    return int'((bits_held >> (bits_avail - n)) & ((64'd1 << n) - 1));
  endfunction

  function automatic void drop_stream(input int unsigned n);
    bits_avail = (n > bits_avail) ? 0 : bits_avail - n;
    bits_held &= (64'd1 << bits_avail) - 1;
  endfunction

  // Decode one difference for column parity p; returns (diff << 2) | low.
  function automatic logic [31:0] decode_difference(input int p);
    int unsigned bias, nlow, b, lz, high, mag;
    logic [1:0]  low;
    logic        neg;
    int          s, diff;
    bias = (quiet_run[p] < 3) ? 2 : 0;
    nlow = sig_bits(prev_mag[p] & 32'hFFFF);
    nlow = (nlow > bias) ? nlow - bias : 0;
    if (nlow < 2 + bias) nlow = 2 + bias;
    b    = peek_stream(15);
    neg  = b[14];
    low  = b[13:12];
    lz   = 12 - sig_bits(b & 32'hFFF);
    if (lz != 12) begin
      drop_stream(lz + 4);
      high = lz;
    end else begin
      drop_stream(15);
      // escape code; a long low part leaves no high bits
      if (nlow <= 15) begin
        high = peek_stream(15 - nlow);
        drop_stream(16 - nlow);
      end else begin
        high = 0;
      end
    end
    mag = (high << nlow) | peek_stream(nlow);
    drop_stream(nlow);
    prev_mag[p] = mag;
    s = neg ? -int'(mag) - 1 : int'(mag);
    diff = s + carry_bias[p];
    carry_bias[p] = (diff * 3 + carry_bias[p]) >>> 5;
    if (mag > 16) quiet_run[p] = 0;
    else if (quiet_run[p] < 3) quiet_run[p]++;
    return (32'(diff) << 2) | 32'(low);
  endfunction

  function automatic void clear_carry_sets();
    for (int i = 0; i < 2; i++) begin
      prev_mag[i]   = 0;
      carry_bias[i] = 0;
      quiet_run[i]  = 0;
    end
  endfunction

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Queue the pixels one accepted byte produces.
  function automatic void predict_pixels(input logic [7:0] b);
    int unsigned w, h, col, row, base, p, n;
    int          pred, left, up, nw, lm, um;
    logic [15:0] up_old;
    logic [31:0] dd, sum;
    pixel_word_t pw;
    n = 0;
    if (image_finished) return;
    if (header_todo != 0) begin
      header_todo--;
      return;
    end
    bits_held  = ((bits_held << 8) | 64'(b)) & ((64'd1 << 48) - 1);
    bits_avail += 8;
    while (n < 2 && bits_avail >= 32 && !image_finished) begin
      w = shadow_width;
      h = shadow_height;
      if (w > WMax) w = WMax;
      w &= ~32'd1;
      if (w < 2) w = 2;
      if (h > HMax) h = HMax;
      if (h < 2) h = 2;
      col = (cur_col >= WMax) ? WMax - 1 : cur_col;
      row = cur_row;
      p = col & 1;
      dd = decode_difference(p);
      base = (row & 1) * WMax;
      up_old = row_pair[base + col];
      if (row < 2 && col < 2) begin
        pred = 0;
      end else if (row < 2) begin
        pred = row_pair[base + col - 2];
      end else if (col < 2) begin
        pred = up_old;
      end else begin
        left = row_pair[base + col - 2];
        up   = up_old;
        nw   = upleft_pix[p];
        lm   = left - nw;
        um   = up - nw;
        if (((lm < 0) != (um < 0)) && lm != 0 && um != 0) begin
          if (iabs(lm) > 32 || iabs(um) > 32) pred = left + um;
          else pred = (left + up) >>> 1;
        end else begin
          pred = (iabs(lm) > iabs(um)) ? left : up;
        end
      end
      upleft_pix[p] = up_old;
      sum = 32'(pred) + dd;
      pw.pix = sum[15:0];
      row_pair[base + col] = sum[15:0];
      pw.eor  = (col + 1 >= w);
      pw.eoi  = pw.eor && (row + 1 >= h);
      pw.last = 1'b0;
      if (pw.eor) begin
        cur_col = 0;
        clear_carry_sets();
        if (pw.eoi) image_finished = 1'b1;
        else cur_row = row + 1;
      end else begin
        cur_col = col + 1;
      end
      pending_pixels.push_back(pw);
      n++;
    end
    if (n > 0) pending_pixels[$].last = 1'b1;
  endfunction

  // ---------------- output side ----------------

  // Receiver: a long hold when asked, otherwise a stall pattern of its own.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (stall_phase == 0) begin
        stall_pattern <= 16'($urandom);
        stall_mode    <= $urandom_range(0, 3);
      end
      stall_phase <= (stall_phase + 1) % 64;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= stall_pattern[stall_phase % 16];
        2: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= stall_pattern[stall_phase % 16] & stall_pattern[(stall_phase + 5) % 16];
      endcase
    end
  end

  // Compare every accepted pixel with the oldest expectation.
  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", pixel_value));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_value !== want.pix)
          report_mismatch($sformatf("pixel_value %h want %h", pixel_value, want.pix));
        if (end_of_row !== want.eor)
          report_mismatch($sformatf("end_of_row %b want %b", end_of_row, want.eor));
        if (end_of_image !== want.eoi)
          report_mismatch($sformatf("end_of_image %b want %b", end_of_image, want.eoi));
        if (last_of_item !== want.last)
          report_mismatch($sformatf("last_of_item %b want %b", last_of_item, want.last));
      end
    end
  end

  // ---------------- input side ----------------

  // Offer one byte from a falling edge; returns at the falling edge after it was taken.
  task automatic send_byte(input logic [7:0] b);
    in_valid  = 1'b1;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    predict_pixels(b);
    @(negedge clk);
  endtask

  task automatic write_reg(input rid_pkg::reg_index_t idx, input logic [14:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == rid_pkg::REG_WIDTH) shadow_width = val;
    else shadow_height = val[13:0];
  endtask

  // Wait until every expected pixel came out, then let the pipe settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] stream_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'($urandom) & 8'($urandom);
      default: return 8'($urandom) | 8'hF0;
    endcase
  endfunction

  // Random bytes, in bursts with random gaps when gaps is set.
  task automatic feed_stream(input int count, input bit gaps);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (gaps && burst == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst = $urandom_range(1, 20);
      end
      send_byte(stream_byte());
      if (burst > 0) burst--;
    end
    in_valid = 1'b0;
  endtask

  // ---------------- tests ----------------

  // Header, then hand-picked bytes on a huge first row.
  task automatic test_header_and_directed();
    logic [7:0] picks[$];
    picks = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE,
              8'h00, 8'h00, 8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'h12, 8'h00};
    write_reg(rid_pkg::REG_WIDTH, 15'h7FFF);
    write_reg(rid_pkg::REG_HEIGHT, 15'h3FFF);
    send_byte(8'hFF);
    for (int i = 1; i < rid_pkg::HeaderBytes; i++) send_byte(8'($urandom));
    foreach (picks[i]) send_byte(picks[i]);
    drain();
  endtask

  // Narrow rows (odd width rounds down), random traffic with gaps.
  task automatic test_random_traffic();
    write_reg(rid_pkg::REG_WIDTH, 15'd7);
    feed_stream(300, 1'b1);
    drain();
  endtask

  // Receiver holds off long while the sender keeps going.
  task automatic test_output_backpressure();
    write_reg(rid_pkg::REG_WIDTH, 15'd4);
    hold_cycles = 400;
    feed_stream(250, 1'b0);
    drain();
  endtask

  // Sender pauses until all pixels are out, in the middle of traffic.
  task automatic test_drain_pause();
    write_reg(rid_pkg::REG_WIDTH, 15'd2);
    feed_stream(120, 1'b1);
    drain();
    feed_stream(120, 1'b1);
    drain();
  endtask

  // Tiny height closes the image; later bytes must yield nothing.
  task automatic test_image_end();
    write_reg(rid_pkg::REG_HEIGHT, 15'd0);
    while (!image_finished) send_byte(stream_byte());
    feed_stream(20, 1'b1);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rid_pkg::REG_WIDTH;
    cfg_data = '0;
    fail_count = 0;
    hold_cycles = 0;
    stall_mode = 0;
    stall_pattern = '0;
    stall_phase = 0;
    shadow_width = 15'(rid_pkg::WidthReset);
    shadow_height = 14'(rid_pkg::HeightReset);
    bits_held = '0;
    bits_avail = 0;
    header_todo = rid_pkg::HeaderBytes;
    cur_row = 0;
    cur_col = 0;
    image_finished = 1'b0;
    clear_carry_sets();
    upleft_pix[0] = '0;
    upleft_pix[1] = '0;
    foreach (row_pair[i]) row_pair[i] = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_header_and_directed();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();
    test_image_end();

    if (fail_count == 0) begin
      $display("** raw_image_difference_decoder_unit: PASSED **");
    end else begin
      $display("** raw_image_difference_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
